/* src/tds_pkg.sv */
package tds_pkg;

   localparam int PEND_W = 5;

   typedef enum logic {
      MODE_ADD      = 1'b0,
      MODE_DISPATCH = 1'b1
   } mode_type;

   typedef enum logic [1:0] {
      POL_FCFS = 2'd0,
      POL_SJF  = 2'd1,
      POL_PRIO = 2'd2
   } policy_type;

   typedef enum logic [1:0] {
      ST_OK    = 2'd0,
      ST_FULL  = 2'd1,
      ST_EMPTY = 2'd2
   } status_type;

   typedef enum logic [1:0] {
      CS_IDLE,
      CS_SCAN,
      CS_SHIFT,
      CS_DONE
   } ctrl_state_type;

   typedef struct packed {
      logic respond_now;
      logic scan_start;
      logic scan_run;
      logic shift_start;
      logic shift_run;
      logic finish;
   } dp_cmd_type;

   typedef struct packed {
      logic count_zero;
      logic scan_done;
      logic shift_done;
   } dp_status_type;

endpackage

/* src/tds_ctrl.sv */
module tds_ctrl
   import tds_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          req_valid,
   input  logic          req_mode,
   output logic          req_stall,
   output logic          rsp_valid,
   input  logic          rsp_stall,
   input  dp_status_type dp_status,
   output dp_cmd_type    dp_cmd
);

   ctrl_state_type state_ff, state_in;
   logic           rsp_valid_ff, rsp_valid_in;
   logic           out_free;
   logic           accept;
   logic           rsp_load;

   // output register is free if empty or being drained this cycle
   assign out_free = !rsp_valid_ff || !rsp_stall;
   assign accept   = req_valid && (state_ff == CS_IDLE) && out_free;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         CS_IDLE: begin
            if (accept && (req_mode == MODE_DISPATCH) && !dp_status.count_zero) begin
               state_in = CS_SCAN;
            end
         end
         CS_SCAN: begin
            if (dp_status.scan_done) begin
               state_in = CS_SHIFT;
            end
         end
         CS_SHIFT: begin
            if (dp_status.shift_done) begin
               state_in = CS_DONE;
            end
         end
         CS_DONE: begin
            if (out_free) begin
               state_in = CS_IDLE;
            end
         end
         default: state_in = CS_IDLE;
      endcase
   end

   always_comb begin
      dp_cmd    = '0;
      req_stall = 1'b1;
      rsp_load  = 1'b0;
      unique case (state_ff)
         CS_IDLE: begin
            req_stall = !out_free;
            if (accept) begin
               if ((req_mode == MODE_DISPATCH) && !dp_status.count_zero) begin
                  dp_cmd.scan_start = 1'b1;
               end else begin
                  dp_cmd.respond_now = 1'b1;
                  rsp_load           = 1'b1;
               end
            end
         end
         CS_SCAN: begin
            if (dp_status.scan_done) begin
               dp_cmd.shift_start = 1'b1;
            end else begin
               dp_cmd.scan_run = 1'b1;
            end
         end
         CS_SHIFT: begin
            dp_cmd.shift_run = !dp_status.shift_done;
         end
         CS_DONE: begin
            if (out_free) begin
               dp_cmd.finish = 1'b1;
               rsp_load      = 1'b1;
            end
         end
         default: begin
            req_stall = 1'b1;
         end
      endcase
   end

   assign rsp_valid_in = rsp_load || (rsp_valid_ff && rsp_stall);
   assign rsp_valid    = rsp_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= CS_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   a_busy_stalls: assert property (@(posedge clock) disable iff (reset)
      (state_ff != CS_IDLE) |-> req_stall)
      else $error("input taken while a dispatch is in progress");

   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_stall) |-> !rsp_load)
      else $error("pending result overwritten");

   a_finish_from_done: assert property (@(posedge clock) disable iff (reset)
      dp_cmd.finish |-> (state_ff == CS_DONE) && $past(state_ff != CS_IDLE))
      else $error("dispatch finished without a scan");

endmodule

/* src/tds_datapath.sv */
module tds_datapath
   import tds_pkg::*;
#(
   parameter int TABLE_DEPTH = 16
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          csr_wr_en,
   input  logic [1:0]    csr_wr_data,
   input  logic          req_mode,
   input  logic [7:0]    req_task_tag,
   input  logic [7:0]    req_task_priority,
   input  logic [15:0]   req_task_burst,
   input  dp_cmd_type    dp_cmd,
   output dp_status_type dp_status,
   output logic [1:0]    rsp_status,
   output logic [7:0]    rsp_out_tag,
   output logic [7:0]    rsp_out_priority,
   output logic [15:0]   rsp_out_burst,
   output logic [PEND_W-1:0] rsp_pending
);

   localparam int CNT_W = $clog2(TABLE_DEPTH + 1);
   localparam int IDX_W = $clog2(TABLE_DEPTH);

   logic [31:0]       mem [TABLE_DEPTH];

   logic [1:0]        policy_ff, policy_in;
   logic [CNT_W-1:0]  count_ff, count_in;
   logic [CNT_W-1:0]  ptr_ff, ptr_in;
   logic              data_vld_ff, data_vld_in;
   logic [IDX_W-1:0]  data_idx_ff, data_idx_in;
   logic [31:0]       data_ff;
   logic [31:0]       best_ff, best_in;
   logic [IDX_W-1:0]  best_idx_ff, best_idx_in;

   logic [1:0]        rsp_status_ff, rsp_status_in;
   logic [31:0]       rsp_entry_ff, rsp_entry_in;
   logic [PEND_W-1:0] rsp_pending_ff, rsp_pending_in;

   logic              count_full;
   logic              add_ok;
   logic [CNT_W-1:0]  scan_end;
   logic [CNT_W-1:0]  rd_limit;
   logic              rd_en;
   logic [IDX_W-1:0]  rd_addr;
   logic              wr_en;
   logic [IDX_W-1:0]  wr_addr;
   logic [31:0]       wr_data;
   logic              key_less;

   assign count_full = (count_ff == CNT_W'(TABLE_DEPTH));
   assign add_ok     = dp_cmd.respond_now && (req_mode == MODE_ADD) && !count_full;

   // first come first served only needs the head entry
   assign scan_end = ((policy_ff == POL_SJF) || (policy_ff == POL_PRIO)) ? count_ff
                                                                          : CNT_W'(1);
   assign rd_limit = dp_cmd.scan_run ? scan_end : count_ff;
   assign rd_en    = (dp_cmd.scan_run || dp_cmd.shift_run) && (ptr_ff < rd_limit);
   assign rd_addr  = ptr_ff[IDX_W-1:0];

   always_comb begin
      unique case (policy_ff)
         POL_SJF:  key_less = data_ff[15:0]  < best_ff[15:0];
         POL_PRIO: key_less = data_ff[23:16] < best_ff[23:16];
         default:  key_less = 1'b0;
      endcase
   end

   always_comb begin
      wr_en   = 1'b0;
      wr_addr = count_ff[IDX_W-1:0];
      wr_data = {req_task_tag, req_task_priority, req_task_burst};
      if (add_ok) begin
         wr_en = 1'b1;
      end else if (dp_cmd.shift_run && data_vld_ff) begin
         // close the gap: entry read in the previous cycle moves down one place
         wr_en   = 1'b1;
         wr_addr = data_idx_ff - 1'b1;
         wr_data = data_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         data_ff <= mem[rd_addr];
      end
   end

   always_comb begin
      policy_in = csr_wr_en ? csr_wr_data : policy_ff;

      ptr_in = ptr_ff;
      if (dp_cmd.scan_start) begin
         ptr_in = '0;
      end else if (dp_cmd.shift_start) begin
         ptr_in = CNT_W'(best_idx_ff) + 1'b1;
      end else if (rd_en) begin
         ptr_in = ptr_ff + 1'b1;
      end

      data_vld_in = rd_en;
      data_idx_in = rd_addr;

      best_in     = best_ff;
      best_idx_in = best_idx_ff;
      if (dp_cmd.scan_run && data_vld_ff) begin
         if ((data_idx_ff == '0) || key_less) begin
            best_in     = data_ff;
            best_idx_in = data_idx_ff;
         end
      end

      count_in = count_ff;
      if (add_ok) begin
         count_in = count_ff + 1'b1;
      end else if (dp_cmd.finish) begin
         count_in = count_ff - 1'b1;
      end

      rsp_status_in  = rsp_status_ff;
      rsp_entry_in   = rsp_entry_ff;
      rsp_pending_in = rsp_pending_ff;
      if (dp_cmd.respond_now) begin
         rsp_entry_in   = '0;
         rsp_pending_in = PEND_W'(count_in);
         if (req_mode == MODE_ADD) begin
            rsp_status_in = count_full ? ST_FULL : ST_OK;
         end else begin
            rsp_status_in = ST_EMPTY;
         end
      end else if (dp_cmd.finish) begin
         rsp_status_in  = ST_OK;
         rsp_entry_in   = best_ff;
         rsp_pending_in = PEND_W'(count_in);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         policy_ff   <= POL_FCFS;
         count_ff    <= '0;
         ptr_ff      <= '0;
         data_vld_ff <= 1'b0;
      end else begin
         policy_ff   <= policy_in;
         count_ff    <= count_in;
         ptr_ff      <= ptr_in;
         data_vld_ff <= data_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      data_idx_ff    <= data_idx_in;
      best_ff        <= best_in;
      best_idx_ff    <= best_idx_in;
      rsp_status_ff  <= rsp_status_in;
      rsp_entry_ff   <= rsp_entry_in;
      rsp_pending_ff <= rsp_pending_in;
   end

   assign dp_status.count_zero = (count_ff == '0);
   assign dp_status.scan_done  = (ptr_ff >= scan_end) && !data_vld_ff;
   assign dp_status.shift_done = (ptr_ff >= count_ff) && !data_vld_ff;

   assign rsp_status       = rsp_status_ff;
   assign rsp_out_tag      = rsp_entry_ff[31:24];
   assign rsp_out_priority = rsp_entry_ff[23:16];
   assign rsp_out_burst    = rsp_entry_ff[15:0];
   assign rsp_pending      = rsp_pending_ff;

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(TABLE_DEPTH))
      else $error("task count beyond table depth");

   a_read_in_range: assert property (@(posedge clock) disable iff (reset)
      rd_en |-> (CNT_W'(rd_addr) < count_ff))
      else $error("read of an entry past the last pending task");

   a_finish_dec: assert property (@(posedge clock) disable iff (reset)
      dp_cmd.finish |=> (count_ff == $past(count_ff) - 1'b1))
      else $error("dispatch did not remove exactly one task");

endmodule

/* src/task_dispatch_scheduler.sv */
// Non-preemptive task dispatcher with a table of TABLE_DEPTH pending tasks kept
// in arrival order in a single-port-write, registered-read memory. An add
// transfer appends a task (or reports full) and its result is ready in the next
// cycle. A dispatch transfer on a non-empty table first scans the table one
// entry per cycle for the pick (only the head entry under first come first
// served), then moves the later entries down one place per cycle. A dispatch
// on an empty table answers like an add. The policy register may only be
// written while no transfer is outstanding; code 3 acts as first come first
// served.
module task_dispatch_scheduler
   import tds_pkg::*;
#(
   parameter int TABLE_DEPTH = 16
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              csr_wr_en,
   input  logic [1:0]        csr_wr_data,
   input  logic              req_valid,
   output logic              req_stall,
   input  logic              req_mode,
   input  logic [7:0]        req_task_tag,
   input  logic [7:0]        req_task_priority,
   input  logic [15:0]       req_task_burst,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output logic [1:0]        rsp_status,
   output logic [7:0]        rsp_out_tag,
   output logic [7:0]        rsp_out_priority,
   output logic [15:0]       rsp_out_burst,
   output logic [PEND_W-1:0] rsp_pending
);

   dp_cmd_type    dp_cmd;
   dp_status_type dp_status;

   tds_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_mode  (req_mode),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .dp_status (dp_status),
      .dp_cmd    (dp_cmd)
   );

   tds_datapath #(
      .TABLE_DEPTH (TABLE_DEPTH)
   ) u_datapath (
      .clock             (clock),
      .reset             (reset),
      .csr_wr_en         (csr_wr_en),
      .csr_wr_data       (csr_wr_data),
      .req_mode          (req_mode),
      .req_task_tag      (req_task_tag),
      .req_task_priority (req_task_priority),
      .req_task_burst    (req_task_burst),
      .dp_cmd            (dp_cmd),
      .dp_status         (dp_status),
      .rsp_status        (rsp_status),
      .rsp_out_tag       (rsp_out_tag),
      .rsp_out_priority  (rsp_out_priority),
      .rsp_out_burst     (rsp_out_burst),
      .rsp_pending       (rsp_pending)
   );

endmodule

/* verif/tb_task_dispatch_scheduler.sv */
module tb_task_dispatch_scheduler
   import tds_pkg::*;
();

   timeunit 1ns;
   timeprecision 1ps;

   localparam int         TABLE_DEPTH = 16;
   localparam logic [1:0] POL_UNUSED  = 2'd3;   // spare code, acts as first come first served

   typedef struct packed {
      logic [7:0]  tag;
      logic [7:0]  prio;
      logic [15:0] burst;
   } task_entry_type;

   typedef struct packed {
      status_type        status;
      logic [7:0]        tag;
      logic [7:0]        prio;
      logic [15:0]       burst;
      logic [PEND_W-1:0] pending;
   } task_result_type;

   logic              clock = 1'b0;
   logic              reset = 1'b1;
   logic              csr_wr_en = 1'b0;
   logic [1:0]        csr_wr_data = '0;
   logic              req_valid = 1'b0;
   logic              req_stall;
   logic              req_mode = 1'b0;
   logic [7:0]        req_task_tag = '0;
   logic [7:0]        req_task_priority = '0;
   logic [15:0]       req_task_burst = '0;
   logic              rsp_valid;
   logic              rsp_stall = 1'b0;
   logic [1:0]        rsp_status;
   logic [7:0]        rsp_out_tag;
   logic [7:0]        rsp_out_priority;
   logic [15:0]       rsp_out_burst;
   logic [PEND_W-1:0] rsp_pending;

   // predictor state
   task_entry_type  pending_tasks[$];
   logic [1:0]      sched_policy = POL_FCFS;
   task_result_type expected_results[$];

   int send_idle_pct = 28;
   int recv_idle_pct = 55;
   int error_count = 0;
   int results_checked = 0;
   int adds_sent = 0;
   int dispatches_sent = 0;
   int full_rejects = 0;
   int empty_dispatches = 0;
   int policy_writes = 0;

   task_dispatch_scheduler #(
      .TABLE_DEPTH(TABLE_DEPTH)
   ) i_dut (
      .clock            (clock),
      .reset            (reset),
      .csr_wr_en        (csr_wr_en),
      .csr_wr_data      (csr_wr_data),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_mode         (req_mode),
      .req_task_tag     (req_task_tag),
      .req_task_priority(req_task_priority),
      .req_task_burst   (req_task_burst),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_status       (rsp_status),
      .rsp_out_tag      (rsp_out_tag),
      .rsp_out_priority (rsp_out_priority),
      .rsp_out_burst    (rsp_out_burst),
      .rsp_pending      (rsp_pending)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   always @(negedge clock) begin
      rsp_stall <= (recv_idle_pct != 0) && ($urandom_range(99) < recv_idle_pct);
   end

   // Applies one item to the scheduler state and returns what the block must answer.
   function automatic task_result_type schedule_item(mode_type mode, task_entry_type item);
      task_result_type res;
      int              pick;
      res = '0;
      res.status = ST_OK;
      if (mode == MODE_ADD) begin
         if (pending_tasks.size() >= TABLE_DEPTH) begin
            res.status = ST_FULL;
            full_rejects++;
         end else begin
            pending_tasks = {pending_tasks, item};
         end
      end else if (pending_tasks.size() == 0) begin
         res.status = ST_EMPTY;
         empty_dispatches++;
      end else begin
         pick = 0;
         // strict compare keeps the earliest task on a tie
         for (int i = 1; i < pending_tasks.size(); i++) begin
            if (sched_policy == POL_SJF && pending_tasks[i].burst < pending_tasks[pick].burst)
               pick = i;
            else if (sched_policy == POL_PRIO && pending_tasks[i].prio < pending_tasks[pick].prio)
               pick = i;
         end
         res.tag   = pending_tasks[pick].tag;
         res.prio  = pending_tasks[pick].prio;
         res.burst = pending_tasks[pick].burst;
         pending_tasks.delete(pick);
      end
      res.pending = PEND_W'(pending_tasks.size());
      return res;
   endfunction

   function automatic logic [15:0] pick_value(int unsigned max_val);
      case ($urandom_range(5))
         0, 1:    return 16'($urandom_range(3));        // crowd values to force ties
         2:       return ($urandom_range(1) != 0) ? 16'(max_val) : 16'd0;
         default: return 16'($urandom_range(max_val));
      endcase
   endfunction

   function automatic task_entry_type random_task();
      task_entry_type item;
      item.tag   = 8'($urandom_range(255));
      item.prio  = 8'(pick_value(255));
      item.burst = pick_value(65535);
      return item;
   endfunction

   task automatic check_field(input string name, input logic [15:0] expv,
                              input logic [15:0] actv);
      if (actv !== expv) begin
         $error("%s mismatch: expected %0d, got %0d", name, expv, actv);
         error_count++;
      end
   endtask

   always @(posedge clock) begin
      task_result_type exp_res;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_results.size() == 0) begin
            $error("result transfer with nothing outstanding");
            error_count++;
         end else begin
            exp_res = expected_results.pop_front();
            check_field("status", 16'(exp_res.status), 16'(rsp_status));
            check_field("out_tag", 16'(exp_res.tag), 16'(rsp_out_tag));
            check_field("out_priority", 16'(exp_res.prio), 16'(rsp_out_priority));
            check_field("out_burst", exp_res.burst, rsp_out_burst);
            check_field("pending", 16'(exp_res.pending), 16'(rsp_pending));
            results_checked++;
         end
      end
   end

   // Valid is left high after the transfer; the next call or a drain decides at the
   // following falling edge.
   task automatic send_item(input mode_type mode, input task_entry_type item);
      @(negedge clock);
      if (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
         req_valid = 1'b0;
         repeat ($urandom_range(3, 1)) @(negedge clock);
      end
      req_valid         = 1'b1;
      req_mode          = mode;
      req_task_tag      = item.tag;
      req_task_priority = item.prio;
      req_task_burst    = item.burst;
      do @(posedge clock); while (req_stall);
      expected_results = {expected_results, schedule_item(mode, item)};
      if (mode == MODE_ADD) adds_sent++;
      else dispatches_sent++;
   endtask

   task automatic wait_for_results();
      @(negedge clock);
      req_valid = 1'b0;
      while (expected_results.size() != 0) @(posedge clock);
   endtask

   task automatic write_policy(input logic [1:0] pol);
      wait_for_results();
      @(negedge clock);
      csr_wr_en   = 1'b1;
      csr_wr_data = pol;
      @(negedge clock);
      csr_wr_en    = 1'b0;
      sched_policy = pol;
      policy_writes++;
   endtask

   task automatic test_empty_dispatch();
      send_item(MODE_DISPATCH, random_task());
   endtask

   // Fills the table with field extremes and tied keys, then one add past full.
   task automatic test_fill_to_full();
      task_entry_type item;
      for (int i = 0; i < TABLE_DEPTH; i++) begin
         item.tag   = 8'(i * 17);
         item.prio  = (i == 10 || i == 15) ? 8'd0 : 8'(255 - i);
         item.burst = (i == 3 || i == 7) ? 16'd0 :
                      (i == 1) ? 16'hFFFF : 16'(16'h1000 * i + 16'h0100);
         send_item(MODE_ADD, item);
      end
      item = '{tag: 8'hA5, prio: 8'h5A, burst: 16'h1234};
      send_item(MODE_ADD, item);
   endtask

   task automatic test_policy_picks();
      write_policy(POL_SJF);
      send_item(MODE_DISPATCH, random_task());
      write_policy(POL_PRIO);
      send_item(MODE_DISPATCH, random_task());
      write_policy(POL_UNUSED);
      send_item(MODE_DISPATCH, random_task());
      write_policy(POL_FCFS);
      send_item(MODE_DISPATCH, random_task());
   endtask

   // Runs of add-heavy, drain-heavy and mixed traffic so the table swings between
   // empty and full; now and then the sender holds off until everything is back.
   task automatic test_random_traffic(input int n_items);
      int sent;
      int add_pct;
      int run_len;
      sent = 0;
      while (sent < n_items) begin
         case ($urandom_range(3))
            0:       add_pct = 85;
            1:       add_pct = 20;
            2:       add_pct = 50;
            default: add_pct = 65;
         endcase
         run_len = $urandom_range(40, 8);
         for (int j = 0; j < run_len && sent < n_items; j++) begin
            send_item(($urandom_range(99) < add_pct) ? MODE_ADD : MODE_DISPATCH,
                      random_task());
            sent++;
         end
         if ($urandom_range(7) == 0) wait_for_results();
      end
   endtask

   initial begin
      int first_pol;
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      test_empty_dispatch();
      test_fill_to_full();
      test_policy_picks();

      for (int phase = 0; phase < 3; phase++) begin
         case (phase)
            0: begin send_idle_pct = 28; recv_idle_pct = 55; end
            1: begin send_idle_pct = 55; recv_idle_pct = 28; end
            default: begin send_idle_pct = 0; recv_idle_pct = 0; end
         endcase
         first_pol = $urandom_range(3);
         for (int k = 0; k < 4; k++) begin
            write_policy(2'((first_pol + k) % 4));
            test_random_traffic(140);
         end
      end

      wait_for_results();
      repeat (2 * TABLE_DEPTH + 8) @(posedge clock);

      $display("Sent %0d adds and %0d dispatches over all four policy codes, %0d policy writes",
               adds_sent, dispatches_sent, policy_writes);
      $display("Checked %0d results: %0d full-table rejects, %0d empty-table dispatches",
               results_checked, full_rejects, empty_dispatches);
      if (error_count == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

   initial begin
      #10_000_000;
      $display("Verification failed");
      $finish;
   end

endmodule

/* filelist.f */
src/tds_pkg.sv
src/tds_ctrl.sv
src/tds_datapath.sv
src/task_dispatch_scheduler.sv
verif/tb_task_dispatch_scheduler.sv
